FILE: hw/rtl/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Item types, kind codes and the per-item work descriptor shared by the
// framebuffer blitter core, its step generator and its checker.
// ----------------------------------------------------------------------------
package mpfb_pkg;

    localparam logic [2:0] K_CLEAR  = 3'd0;
    localparam logic [2:0] K_PIXEL  = 3'd1;
    localparam logic [2:0] K_ICON   = 3'd2;
    localparam logic [2:0] K_GLYPH  = 3'd3;
    localparam logic [2:0] K_DOUBLE = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] x;
        logic [7:0] y;
        logic       on;
        logic [7:0] width;
        logic [6:0] height;
        logic [7:0] pattern;
        logic       first;
        logic [8:0] address;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [8:0] read_address;
    } t_out;

    typedef enum logic [1:0] {
        MD_ICON,
        MD_SINGLE,
        MD_DOUBLE
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic        set;
        logic [7:0]  en;
        logic [10:0] xbase;
        logic [9:0]  row;
        logic [23:0] bits;
        logic [2:0]  last;
    } t_ctx;

endpackage

FILE: hw/rtl/mpfb_step.sv
// ----------------------------------------------------------------------------
// mpfb_step
// Maps one step of an item to a frame byte address and a bit mask, and
// clips the step against the frame edges.
// ----------------------------------------------------------------------------
module mpfb_step #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32,
    parameter int AW           = 9
) (
    input  mpfb_pkg::t_ctx i_ctx,
    input  logic [2:0]     i_step,
    output logic           o_hit,
    output logic [AW-1:0]  o_addr,
    output logic [7:0]     o_mask
);
    import mpfb_pkg::*;

    localparam int PAGE_COUNT = (FRAME_HEIGHT + 7) / 8;

    logic [2:0]  colofs;
    logic [1:0]  pg;
    logic [10:0] col;
    logic [7:0]  page;
    logic        col_ok;
    logic        page_ok;
    logic [7:0]  sel;
    logic [7:0]  rowlim;

    always_comb begin
        unique case (i_ctx.mode)
            MD_ICON: begin
                colofs = i_step;
                pg     = 2'd0;
            end
            MD_SINGLE: begin
                colofs = 3'd0;
                pg     = i_step[1:0];
            end
            MD_DOUBLE: begin
                colofs = {2'b0, i_step[0]};
                pg     = i_step[2:1];
            end
            default: begin
                colofs = 3'd0;
                pg     = 2'd0;
            end
        endcase
    end

    assign col     = i_ctx.xbase + {8'b0, colofs};
    assign page    = {i_ctx.row[9], i_ctx.row[9:3]} + {6'b0, pg};
    assign col_ok  = !col[10] && (col < 11'(FRAME_WIDTH));
    assign page_ok = !page[7] && (page < 8'(PAGE_COUNT));

    always_comb begin
        unique case (pg)
            2'd0:    sel = i_ctx.bits[7:0];
            2'd1:    sel = i_ctx.bits[15:8];
            2'd2:    sel = i_ctx.bits[23:16];
            default: sel = 8'd0;
        endcase
        for (int k = 0; k < 8; k++) begin
            rowlim[k] = ({3'b0, page[2:0], 3'(k)} < 9'(FRAME_HEIGHT));
        end
    end

    assign o_mask = sel & rowlim;
    assign o_hit  = i_ctx.en[i_step] && col_ok && page_ok && (o_mask != 8'd0);
    assign o_addr = AW'(page[2:0]) * AW'(FRAME_WIDTH) + AW'(col[7:0]);

endmodule

FILE: hw/rtl/mono_page_framebuffer_blitter_core.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blitter_core
// Page-organized one-bit framebuffer with clipped pixel, icon and glyph
// painting, whole-frame clear and byte readback.
// ----------------------------------------------------------------------------
// The frame lives in one single-port-write memory of FRAME_WIDTH times
// ceil(FRAME_HEIGHT/8) bytes, and every paint is a read-modify-write of one
// byte per cycle through that memory. An item occupies the block through
// its accept state, its byte steps in S_RUN and the S_DRAIN state that
// retires the last write; a read item passes from accept to S_READ, which
// registers the result. A clear sweeps the memory one byte a cycle, and the
// same sweep runs after reset before the first item is taken. A read item
// waits while an earlier read result has not been taken; other kinds do not.
module mono_page_framebuffer_blitter_core #(
    parameter int FRAME_WIDTH   = 128,
    parameter int FRAME_HEIGHT  = 32,
    parameter int GLYPH_COLUMNS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mpfb_pkg::t_in    i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mpfb_pkg::t_out   o_out_item
);
    import mpfb_pkg::*;

    localparam int PAGE_COUNT  = (FRAME_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = FRAME_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_READ
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    t_ctx          r_ctx;
    t_ctx          n_ctx;
    logic [2:0]    r_step;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic [7:0]    r_wr_mask;
    logic [7:0]    r_rdata;
    logic          r_rd_ok;
    logic [8:0]    r_rd_addr;
    logic          r_out_valid;
    t_out          r_out_item;
    logic [6:0]    r_icon_row;
    logic [3:0]    r_icon_group;
    logic [2:0]    r_glyph_col;
    logic [6:0]    n_icon_row;
    logic [3:0]    n_icon_group;
    logic [2:0]    n_glyph_col;

    logic [7:0]    mem [STORE_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic          step_hit;
    logic [AW-1:0] step_addr;
    logic [7:0]    step_mask;

    logic          accept;
    logic          rd_ok;
    logic [10:0]   xs;
    logic [9:0]    ys;
    logic [6:0]    eff_row;
    logic [3:0]    eff_g;
    logic          icon_act;
    logic [5:0]    groups;
    logic [4:0]    gsat;
    logic [4:0]    g1;
    logic [2:0]    eff_c;
    logic          g_act;
    logic [23:0]   vbits;

    function automatic logic [15:0] expand(input logic [7:0] p);
        logic [15:0] d;
        for (int i = 0; i < 8; i++) begin
            d[2*i]   = p[i];
            d[2*i+1] = p[i];
        end
        return d;
    endfunction

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && (i_in_item.kind == K_READ));
    assign accept     = i_in_valid && !o_in_stall;
    assign rd_ok      = ({3'b0, i_in_item.address} < 12'(STORE_BYTES));

    assign xs = {{2{i_in_item.x[8]}}, i_in_item.x};
    assign ys = {{2{i_in_item.y[7]}}, i_in_item.y};

    always_comb begin
        eff_row  = i_in_item.first ? 7'd0 : r_icon_row;
        eff_g    = i_in_item.first ? 4'd0 : r_icon_group;
        icon_act = eff_row < i_in_item.height;
        groups   = 6'(({1'b0, i_in_item.width} + 9'd7) >> 3);
        gsat     = (groups > 6'd16) ? 5'd16 : groups[4:0];
        g1       = {1'b0, eff_g} + 5'd1;
        eff_c    = i_in_item.first ? 3'd0 : r_glyph_col;
        g_act    = {1'b0, eff_c} < 4'(GLYPH_COLUMNS);

        n_icon_row   = eff_row;
        n_icon_group = eff_g;
        if (icon_act) begin
            if (g1 >= gsat) begin
                n_icon_group = 4'd0;
                n_icon_row   = eff_row + 7'd1;
            end else begin
                n_icon_group = g1[3:0];
            end
        end
        n_glyph_col = g_act ? eff_c + 3'd1 : eff_c;

        n_ctx       = '0;
        n_ctx.set   = 1'b1;
        n_ctx.en    = 8'hFF;
        n_ctx.xbase = xs;
        n_ctx.row   = ys;
        vbits       = 24'd1;
        unique case (i_in_item.kind)
            K_PIXEL: begin
                n_ctx.mode = MD_SINGLE;
                n_ctx.set  = i_in_item.on;
                n_ctx.last = 3'd0;
            end
            K_ICON: begin
                n_ctx.mode  = MD_ICON;
                n_ctx.last  = 3'd7;
                n_ctx.xbase = xs + {4'b0, eff_g, 3'b0};
                n_ctx.row   = ys + {3'b0, eff_row};
                for (int b = 0; b < 8; b++) begin
                    n_ctx.en[b] = i_in_item.pattern[7-b] && icon_act &&
                                  ({1'b0, eff_g, 3'(b)} < i_in_item.width);
                end
            end
            K_GLYPH: begin
                n_ctx.mode  = MD_SINGLE;
                n_ctx.last  = 3'd1;
                n_ctx.en    = {8{g_act}};
                n_ctx.xbase = xs + {8'b0, eff_c};
                vbits       = {16'b0, i_in_item.pattern};
            end
            K_DOUBLE: begin
                n_ctx.mode  = MD_DOUBLE;
                n_ctx.last  = 3'd5;
                n_ctx.en    = {8{g_act}};
                n_ctx.xbase = xs + {7'b0, eff_c, 1'b0};
                vbits       = {8'b0, expand(i_in_item.pattern)};
            end
            default: begin
                n_ctx.mode = MD_SINGLE;
            end
        endcase
        n_ctx.bits = vbits << n_ctx.row[2:0];
    end

    mpfb_step #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    ) u_step (
        .i_ctx  (r_ctx),
        .i_step (r_step),
        .o_hit  (step_hit),
        .o_addr (step_addr),
        .o_mask (step_mask)
    );

    assign mem_we = (r_state == S_CLEAR) || r_wr_pend;
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : r_wr_addr;
    assign mem_wd = (r_state == S_CLEAR) ? 8'd0 :
                    (r_ctx.set ? (r_rdata | r_wr_mask) : (r_rdata & ~r_wr_mask));
    assign mem_re = ((r_state == S_IDLE) && accept && (i_in_item.kind == K_READ) && rd_ok) ||
                    ((r_state == S_RUN) && step_hit);
    assign mem_ra = (r_state == S_IDLE) ? AW'(i_in_item.address) : step_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_wr_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_icon_row   <= 7'd0;
            r_icon_group <= 4'd0;
            r_glyph_col  <= 3'd0;
        end else begin
            r_wr_pend <= (r_state == S_RUN) && step_hit;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(STORE_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in_item.kind)
                            K_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            K_PIXEL: begin
                                r_ctx   <= n_ctx;
                                r_step  <= 3'd0;
                                r_state <= S_RUN;
                            end
                            K_ICON: begin
                                r_ctx        <= n_ctx;
                                r_step       <= 3'd0;
                                r_state      <= S_RUN;
                                r_icon_row   <= n_icon_row;
                                r_icon_group <= n_icon_group;
                            end
                            K_GLYPH, K_DOUBLE: begin
                                r_ctx       <= n_ctx;
                                r_step      <= 3'd0;
                                r_state     <= S_RUN;
                                r_glyph_col <= n_glyph_col;
                            end
                            K_READ: begin
                                r_rd_ok   <= rd_ok;
                                r_rd_addr <= i_in_item.address;
                                r_state   <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (step_hit) begin
                        r_wr_addr <= step_addr;
                        r_wr_mask <= step_mask;
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == r_ctx.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    r_out_valid             <= 1'b1;
                    r_out_item.read_byte    <= r_rd_ok ? r_rdata : 8'd0;
                    r_out_item.read_address <= r_rd_addr;
                    r_state                 <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hw/rtl/mpfb_checker.sv
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level checks of the framebuffer blitter core: results hold while
// stalled, and read results follow read items and carry the requested address.
// ----------------------------------------------------------------------------
module mpfb_checker #(
    parameter int FRAME_WIDTH   = 128,
    parameter int FRAME_HEIGHT  = 32,
    parameter int GLYPH_COLUMNS = 6
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input mpfb_pkg::t_in  i_in_item,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input mpfb_pkg::t_out o_out_item
);
    import mpfb_pkg::*;

    localparam int STORE_BYTES = FRAME_WIDTH * ((FRAME_HEIGHT + 7) / 8);

    logic rd_acc;
    logic glyph_ok;

    assign rd_acc   = i_in_valid && !o_in_stall && (i_in_item.kind == K_READ);
    assign glyph_ok = GLYPH_COLUMNS > 0;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("Result item dropped while stalled.");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(rd_acc, 2) && glyph_ok))
        else $error("Result item without a read item two cycles earlier.");

    a_read_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_item.read_address == $past(i_in_item.address, 2)))
        else $error("Read result carries the wrong address.");

    a_read_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && ({3'b0, o_out_item.read_address} >= 12'(STORE_BYTES)))
        |-> (o_out_item.read_byte == 8'd0))
        else $error("Read beyond the frame returned nonzero data.");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> o_in_stall)
        else $error("Input taken while a read item is in flight.");

endmodule

bind mono_page_framebuffer_blitter_core mpfb_checker #(
    .FRAME_WIDTH   (FRAME_WIDTH),
    .FRAME_HEIGHT  (FRAME_HEIGHT),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
) u_mpfb_checker (.*);
